>>> hdl/wipf_pkg.sv
package wipf_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_CHARS   = 16;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PLEN_W      = 5;

    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] column;
    } t_win_hit;

    function automatic logic [CHAR_W-1:0] pattern_char(
        input logic [PAT_CHARS*CHAR_W-1:0] pat,
        input logic [LEN_W-1:0]            idx
    );
        logic [CHAR_W-1:0] r;
        r = '0;
        for (int k = 0; k < PAT_CHARS; k++) begin
            if (int'(idx) == k) begin
                r = pat[CHAR_W*k +: CHAR_W];
            end
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] inc_sat(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + POS_W'(1);
    endfunction

endpackage

>>> hdl/wipf_if.sv
interface wipf_in_if;
    logic                          valid;
    logic                          ready;
    logic [wipf_pkg::CHAR_W-1:0]   text_byte;
    logic                          end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wipf_out_if;
    logic                          valid;
    logic                          ready;
    logic [wipf_pkg::POS_W-1:0]    match_line;
    logic [wipf_pkg::POS_W-1:0]    match_column;
    logic [wipf_pkg::POS_W-1:0]    match_total;
    logic                          is_total;

    modport source (output valid, output match_line, output match_column,
                    output match_total, output is_total, input ready);
    modport sink   (input valid, input match_line, input match_column,
                    input match_total, input is_total, output ready);
endinterface

interface wipf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wipf_pkg::CFG_IDX_W-1:0]  index;
    logic [wipf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/wipf_window.sv
module wipf_window (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_shift,
    input  logic [wipf_pkg::CHAR_W-1:0]                          i_char,
    input  logic [wipf_pkg::POS_W-1:0]                           i_line,
    input  logic [wipf_pkg::POS_W-1:0]                           i_column,
    input  logic [wipf_pkg::PAT_CHARS*wipf_pkg::CHAR_W-1:0]      i_pattern,
    input  logic [wipf_pkg::PLEN_W-1:0]                          i_pat_len,
    output wipf_pkg::t_win_hit                                   o_hit
);
    import wipf_pkg::*;

    logic [CHAR_W-1:0] r_chars [MAX_PATTERN];
    logic [POS_W-1:0]  r_lines [MAX_PATTERN];
    logic [POS_W-1:0]  r_cols  [MAX_PATTERN];
    logic [LEN_W-1:0]  r_fill;

    logic [CHAR_W-1:0] n_chars [MAX_PATTERN];
    logic [POS_W-1:0]  n_lines [MAX_PATTERN];
    logic [POS_W-1:0]  n_cols  [MAX_PATTERN];
    logic [LEN_W-1:0]  n_fill;

    logic [LEN_W-1:0]  len_used;
    logic [LEN_W-1:0]  len_m1;
    logic [IDX_W-1:0]  start_sel;
    logic              all_eq;

    always_comb begin
        n_chars[0] = i_char;
        n_lines[0] = i_line;
        n_cols[0]  = i_column;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_chars[k] = r_chars[k-1];
            n_lines[k] = r_lines[k-1];
            n_cols[k]  = r_cols[k-1];
        end
        n_fill = (r_fill == LEN_W'(MAX_PATTERN)) ? r_fill : r_fill + LEN_W'(1);
    end

    always_comb begin
        if (i_pat_len == '0) begin
            len_used = LEN_W'(1);
        end else if (int'(i_pat_len) > MAX_PATTERN) begin
            len_used = LEN_W'(MAX_PATTERN);
        end else begin
            len_used = LEN_W'(i_pat_len);
        end
        len_m1    = len_used - LEN_W'(1);
        start_sel = IDX_W'(len_m1);

        all_eq = (n_fill >= len_used);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if ((LEN_W'(j) < len_used) &&
                (n_chars[j] != pattern_char(i_pattern, len_m1 - LEN_W'(j)))) begin
                all_eq = 1'b0;
            end
        end

        o_hit.hit    = all_eq;
        o_hit.line   = n_lines[start_sel];
        o_hit.column = n_cols[start_sel];
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_chars[k] <= n_chars[k];
                r_lines[k] <= n_lines[k];
                r_cols[k]  <= n_cols[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_shift) begin
            r_fill <= n_fill;
        end
    end

endmodule

>>> hdl/whitespace_insensitive_pattern_finder.sv
// Channel    Dir   Modport  Payload
// i_text     in    sink     text_byte[7:0], end_of_text
// o_match    out   source   match_line[15:0], match_column[15:0], match_total[15:0], is_total
// i_cfg      in    sink     index[1:0] (0 pattern low, 1 pattern high, 2 length), data[63:0]
//
// One item per cycle sustained while the output is not stalled; a result passes the input
// register and then the output register before it is valid.
// Input register -> window shift and parallel compare -> output register.
// Reset (i_rst_n low, synchronous) empties both stages, sets line and column to 1,
// count and window fill to 0, length to 1 and the pattern to zero.
// A stalled output holds the compare stage; the input register keeps taking an item
// as long as it can hand its current one on. i_cfg is always ready.
module whitespace_insensitive_pattern_finder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wipf_in_if.sink   i_text,
    wipf_out_if.source o_match,
    wipf_cfg_if.sink  i_cfg
);
    import wipf_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [PLEN_W-1:0]     r_pat_len;

    logic                  r_in_valid;
    logic [CHAR_W-1:0]     r_in_byte;
    logic                  r_in_eot;

    logic [POS_W-1:0]      r_line;
    logic [POS_W-1:0]      r_col;
    logic [POS_W-1:0]      r_count;

    logic                  r_out_valid;
    logic [POS_W-1:0]      r_out_line;
    logic [POS_W-1:0]      r_out_col;
    logic [POS_W-1:0]      r_out_total;
    logic                  r_out_is_total;

    logic                  advance;
    logic                  in_take;
    logic                  blank;
    logic                  shift;
    logic                  found;
    logic [POS_W-1:0]      count_inc;
    t_win_hit              win;

    assign advance   = r_in_valid && (!r_out_valid || o_match.ready);
    assign in_take   = i_text.valid && i_text.ready;
    assign blank     = (r_in_byte == CHAR_NL) || (r_in_byte == CHAR_SPACE) ||
                       (r_in_byte == CHAR_TAB);
    assign shift     = advance && !r_in_eot && !blank;
    assign found     = shift && win.hit;
    assign count_inc = inc_sat(r_count);

    assign i_text.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    assign o_match.valid        = r_out_valid;
    assign o_match.match_line   = r_out_line;
    assign o_match.match_column = r_out_col;
    assign o_match.match_total  = r_out_total;
    assign o_match.is_total     = r_out_is_total;

    wipf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (shift),
        .i_char    (r_in_byte),
        .i_line    (r_line),
        .i_column  (r_col),
        .i_pattern ({r_pat_high, r_pat_low}),
        .i_pat_len (r_pat_len),
        .o_hit     (win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= PLEN_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_PAT_LOW:  r_pat_low  <= i_cfg.data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg.data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg.data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_text.text_byte;
            r_in_eot  <= i_text.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= POS_W'(1);
            r_col   <= POS_W'(1);
            r_count <= '0;
        end else begin
            if (advance && !r_in_eot) begin
                if (r_in_byte == CHAR_NL) begin
                    r_line <= inc_sat(r_line);
                    r_col  <= POS_W'(1);
                end else begin
                    r_col  <= inc_sat(r_col);
                end
            end
            if (found) begin
                r_count <= count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_eot || found;
        end else if (o_match.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_in_eot) begin
                r_out_line     <= '0;
                r_out_col      <= '0;
                r_out_total    <= r_count;
                r_out_is_total <= 1'b1;
            end else begin
                r_out_line     <= win.line;
                r_out_col      <= win.column;
                r_out_total    <= count_inc;
                r_out_is_total <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/wipf_checker.sv
module wipf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [wipf_pkg::POS_W-1:0] i_line,
    input logic [wipf_pkg::POS_W-1:0] i_column,
    input logic [wipf_pkg::POS_W-1:0] i_total,
    input logic                       i_is_total
);
    import wipf_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_line) && $stable(i_column) &&
             $stable(i_total) && $stable(i_is_total)))
        else $error("output changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_match_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_is_total) |->
            (i_line != '0 && i_column != '0 && i_total != '0))
        else $error("match report with zero position or count");

    a_total_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_total) |-> (i_line == '0 && i_column == '0))
        else $error("total report with nonzero position");

endmodule

bind whitespace_insensitive_pattern_finder wipf_checker u_wipf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_match.valid),
    .i_out_ready (o_match.ready),
    .i_line      (o_match.match_line),
    .i_column    (o_match.match_column),
    .i_total     (o_match.match_total),
    .i_is_total  (o_match.is_total)
);

>>> tb/wipf_match_checker.sv
module wipf_match_checker
    import wipf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    wipf_in_if   i_text,
    wipf_out_if  i_match,
    wipf_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] total;
        logic             is_total;
    } t_match_rec;

    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [PLEN_W-1:0]     pat_len;

    logic [CHAR_W-1:0] win_char [MAX_PATTERN];
    logic [POS_W-1:0]  win_line [MAX_PATTERN];
    logic [POS_W-1:0]  win_col  [MAX_PATTERN];
    int                win_fill;
    logic [POS_W-1:0]  line_now;
    logic [POS_W-1:0]  col_now;
    logic [POS_W-1:0]  found_n;

    t_match_rec match_expect_q[$];
    int         mismatches = 0;
    t_match_rec seen_rec;
    t_match_rec due_rec;
    t_match_rec new_rec;
    logic       new_fires;

    assign o_fail_count = mismatches;

    function automatic logic [POS_W-1:0] bump_sat(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + POS_W'(1);
    endfunction

    task automatic note_mismatch(input string what, input t_match_rec want,
                                 input t_match_rec got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected line %0d column %0d total %0d is_total %0b",
                     what, want.line, want.column, want.total, want.is_total);
            $display("    got line %0d column %0d total %0d is_total %0b",
                     got.line, got.column, got.total, got.is_total);
        end
    endtask

    // total at end of text; else advance position, shift window on non-blank bytes, compare
    task automatic scan_item(input logic [CHAR_W-1:0] ch, input logic eot,
                             output logic fires, output t_match_rec rec);
        logic [POS_W-1:0]            at_line;
        logic [POS_W-1:0]            at_col;
        logic [PAT_CHARS*CHAR_W-1:0] pat_all;
        int                          span;
        logic                        hit;
        fires   = 1'b0;
        rec     = '0;
        pat_all = {pat_high, pat_low};
        span    = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        if (eot) begin
            fires        = 1'b1;
            rec.total    = found_n;
            rec.is_total = 1'b1;
        end else begin
            at_line = line_now;
            at_col  = col_now;
            if (ch == CHAR_NL) begin
                line_now = bump_sat(line_now);
                col_now  = POS_W'(1);
            end else begin
                col_now = bump_sat(col_now);
            end
            if (ch != CHAR_NL && ch != CHAR_SPACE && ch != CHAR_TAB) begin
                for (int k = MAX_PATTERN - 1; k > 0; k--) begin
                    win_char[k] = win_char[k-1];
                    win_line[k] = win_line[k-1];
                    win_col[k]  = win_col[k-1];
                end
                win_char[0] = ch;
                win_line[0] = at_line;
                win_col[0]  = at_col;
                if (win_fill < MAX_PATTERN) begin
                    win_fill++;
                end
                if (win_fill >= span) begin
                    hit = 1'b1;
                    for (int i = 0; i < span; i++) begin
                        if (win_char[span-1-i] != pat_all[CHAR_W*i +: CHAR_W]) begin
                            hit = 1'b0;
                        end
                    end
                    if (hit) begin
                        found_n    = bump_sat(found_n);
                        fires      = 1'b1;
                        rec.line   = win_line[span-1];
                        rec.column = win_col[span-1];
                        rec.total  = found_n;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_low  = '0;
            pat_high = '0;
            pat_len  = PLEN_W'(1);
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_char[k] = '0;
                win_line[k] = '0;
                win_col[k]  = '0;
            end
            win_fill = 0;
            line_now = POS_W'(1);
            col_now  = POS_W'(1);
            found_n  = '0;
            match_expect_q.delete();
        end else begin
            if (i_match.valid && i_match.ready) begin
                seen_rec = '{line: i_match.match_line, column: i_match.match_column,
                             total: i_match.match_total, is_total: i_match.is_total};
                if (match_expect_q.size() == 0) begin
                    note_mismatch("unexpected result", '0, seen_rec);
                end else begin
                    due_rec = match_expect_q.pop_front();
                    if (seen_rec.line !== due_rec.line || seen_rec.column !== due_rec.column
                        || seen_rec.total !== due_rec.total
                        || seen_rec.is_total !== due_rec.is_total) begin
                        note_mismatch("wrong result", due_rec, seen_rec);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_reg'(i_cfg.index))
                    CFG_PAT_LOW:  pat_low  = i_cfg.data;
                    CFG_PAT_HIGH: pat_high = i_cfg.data;
                    CFG_PAT_LEN:  pat_len  = i_cfg.data[PLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_text.valid && i_text.ready) begin
                scan_item(i_text.text_byte, i_text.end_of_text, new_fires, new_rec);
                if (new_fires) begin
                    match_expect_q.push_back(new_rec);
                end
            end
        end
        o_pending <= match_expect_q.size();
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    import wipf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RAND_PHASES    = 13;
    localparam int PHASE_ITEMS    = 100;
    localparam logic [CHAR_W-1:0] CH_A = 8'h61;

    logic i_clk;
    logic i_rst_n;

    wipf_in_if  text_bus ();
    wipf_out_if match_bus ();
    wipf_cfg_if cfg_bus ();

    int fail_count;
    int pending_count;
    bit text_gaps;
    bit match_gaps;
    int hold_req  = 0;
    int hold_done = 0;
    int quiet_cycles;

    logic [PAT_CHARS*CHAR_W-1:0] pat_chars;
    int                          pat_span;
    logic [CHAR_W-1:0]           text_plan[$];

    whitespace_insensitive_pattern_finder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_bus),
        .o_match (match_bus),
        .i_cfg   (cfg_bus)
    );

    wipf_match_checker match_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (text_bus),
        .i_match      (match_bus),
        .i_cfg        (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((text_bus.valid && text_bus.ready) || (match_bus.valid && match_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_done != hold_req) begin
                hold_done = hold_req;
                match_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = match_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                match_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            match_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!match_bus.valid);
        end
    end

    function automatic logic [CHAR_W-1:0] blank_char();
        case ($urandom_range(0, 2))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            default: return CHAR_NL;
        endcase
    endfunction

    task automatic send_text(input logic [CHAR_W-1:0] ch, input logic eot);
        int gap;
        gap = text_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            text_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_bus.valid       <= 1'b1;
        text_bus.text_byte   <= ch;
        text_bus.end_of_text <= eot;
        do @(posedge i_clk); while (!text_bus.ready);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_text(s[i], 1'b0);
        end
    endtask

    task automatic send_eot();
        send_text(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // drop the text channel and wait until the block has drained
    task automatic settle();
        text_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic load_pattern(input logic [PAT_CHARS*CHAR_W-1:0] chars,
                                input logic [PLEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom(), $urandom()};
        len_word[PLEN_W-1:0] = len;
        settle();
        put_reg(CFG_PAT_LOW, chars[CFG_DATA_W-1:0]);
        put_reg(CFG_PAT_HIGH, chars[2*CFG_DATA_W-1:CFG_DATA_W]);
        put_reg(CFG_PAT_LEN, len_word);
        cfg_bus.valid <= 1'b0;
        pat_chars = chars;
        pat_span  = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
    endtask

    task automatic plan_text();
        int pick;
        int cut;
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            for (int i = 0; i < pat_span; i++) begin
                text_plan.push_back(pat_chars[CHAR_W*i +: CHAR_W]);
                if (i < pat_span - 1 && $urandom_range(0, 4) == 0) begin
                    text_plan.push_back(blank_char());
                end
            end
        end else if (pick <= 6) begin
            cut = $urandom_range(1, pat_span);
            for (int i = 0; i < cut; i++) begin
                text_plan.push_back(pat_chars[CHAR_W*i +: CHAR_W]);
            end
        end else if (pick == 7) begin
            repeat ($urandom_range(1, 6))
                text_plan.push_back(CHAR_W'(CH_A + $urandom_range(0, 3)));
        end else if (pick == 8) begin
            repeat ($urandom_range(1, 3)) text_plan.push_back(blank_char());
        end else begin
            repeat ($urandom_range(1, 4)) text_plan.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [PAT_CHARS*CHAR_W-1:0] chars;
        logic [PLEN_W-1:0]           len;
        int                          span;

        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        text_bus.valid       = 1'b0;
        text_bus.text_byte   = '0;
        text_bus.end_of_text = 1'b0;
        match_bus.ready      = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_PAT_LOW;
        cfg_bus.data         = '0;
        text_gaps            = 1'b1;
        match_gaps           = 1'b1;
        pat_chars            = '0;
        pat_span             = 1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pattern: a single zero byte
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_string(" \t\n");
        send_text(8'h00, 1'b0);
        send_eot();

        chars = '0;
        chars[15:0] = 16'h6261;
        load_pattern(chars, PLEN_W'(2));
        send_string("a \nbab");
        send_eot();

        chars = '0;
        chars[7:0] = 8'h78;
        load_pattern(chars, PLEN_W'(0));
        send_string("xy");
        send_eot();

        chars = '0;
        chars[15:0] = {CHAR_SPACE, 8'h71};
        load_pattern(chars, PLEN_W'(2));
        send_string("q q");
        send_eot();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int i = 0; i < PAT_CHARS; i++) begin
                chars[CHAR_W*i +: CHAR_W] = ($urandom_range(0, 9) == 0) ?
                    CHAR_W'($urandom_range(0, 255)) : CHAR_W'(CH_A + $urandom_range(0, 3));
            end
            case (p)
                0:       len = PLEN_W'(1);
                1:       len = PLEN_W'(16);
                2:       len = PLEN_W'(17);
                3:       len = PLEN_W'(31);
                4:       len = PLEN_W'(0);
                5: begin
                    chars = '1;
                    len   = PLEN_W'(3);
                end
                6: begin
                    chars = '0;
                    len   = PLEN_W'(2);
                end
                7:       len = PLEN_W'($urandom_range(1, 16));
                default: len = PLEN_W'($urandom_range(1, 5));
            endcase
            span = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
            if (p != 5 && p != 6) begin
                for (int i = span; i < PAT_CHARS; i++) begin
                    chars[CHAR_W*i +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
                end
            end
            load_pattern(chars, len);
            text_gaps  = (p % 3 != 1);
            match_gaps = (p % 4 != 2);
            if (p == 0) begin
                text_gaps  = 1'b0;
                match_gaps = 1'b0;
                hold_req++;
            end
            text_plan.delete();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (text_plan.size() == 0) begin
                    plan_text();
                end
                send_text(text_plan.pop_front(), 1'b0);
                if ($urandom_range(0, 49) == 0) begin
                    send_eot();
                end
            end
            send_eot();
        end

        // split the pattern across a tab, with a blank and a line break between matches
        text_gaps  = 1'b1;
        match_gaps = 1'b1;
        chars = '0;
        chars[15:0] = 16'h6261;
        load_pattern(chars, PLEN_W'(2));
        send_string("ab a\tb\nab");
        send_eot();

        settle();
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/wipf_pkg.sv
hdl/wipf_if.sv
hdl/wipf_window.sv
hdl/whitespace_insensitive_pattern_finder.sv
hdl/wipf_checker.sv
tb/wipf_match_checker.sv
tb/tb_top.sv
